[hw/rtl/bertlv_pkg.sv]
// Shared types and constants for the BER TLV stream parser.
`default_nettype none
package bertlv_pkg;
    localparam int NEST_DEPTH = 8;
    localparam int POS_W      = 16;
    localparam int SP_W       = $clog2(NEST_DEPTH + 1);
    localparam int IDX_W      = $clog2(NEST_DEPTH);
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
    localparam logic [15:0] MAX_LEN_RST  = 16'd1500;

    localparam logic [2:0] ROLE_TAG  = 3'd0;
    localparam logic [2:0] ROLE_TAGC = 3'd1;
    localparam logic [2:0] ROLE_LEN  = 3'd2;
    localparam logic [2:0] ROLE_LENX = 3'd3;
    localparam logic [2:0] ROLE_CONT = 3'd4;
    localparam logic [2:0] ROLE_EOC  = 3'd5;
    localparam logic [2:0] ROLE_PAD  = 3'd6;

    localparam logic [2:0] ERR_NONE = 3'd0;
    localparam logic [2:0] ERR_EOC  = 3'd1;
    localparam logic [2:0] ERR_LFRM = 3'd2;
    localparam logic [2:0] ERR_MLEN = 3'd3;
    localparam logic [2:0] ERR_OVF  = 3'd4;
    localparam logic [2:0] ERR_LVL  = 3'd5;

    localparam logic [1:0] KIND_INT  = 2'd0;
    localparam logic [1:0] KIND_TICK = 2'd1;
    localparam logic [1:0] KIND_OID  = 2'd2;

    localparam logic [2:0] GCNT_DEAD = 3'd7;

    typedef enum logic [2:0] {
        VC_NONE = 3'd0, VC_INT = 3'd1, VC_TICK = 3'd2, VC_OID = 3'd3, VC_ROID = 3'd4
    } t_vclass;

    typedef struct packed {
        logic [31:0] acc;
        logic [2:0]  gcnt;
        logic        fsp;
    } t_val_st;

    typedef struct packed {
        t_val_st     st;
        logic        ovf;
        logic [1:0]  nvals;
        logic [31:0] v0;
        logic [31:0] v1;
        logic [1:0]  kind;
    } t_val_res;

    function automatic t_vclass value_class(input logic [23:0] tag);
        t_vclass r;
        r = VC_NONE;
        if (!tag[21]) begin
            if (tag[23:22] == 2'd0) begin
                if (tag[20:0] == 21'd2) r = VC_INT;
                else if (tag[20:0] == 21'd6) r = VC_OID;
                else if (tag[20:0] == 21'd13) r = VC_ROID;
            end else if (tag[23:22] == 2'd1) begin
                if (tag[20:0] == 21'd1 || tag[20:0] == 21'd2 || tag[20:0] == 21'd7) r = VC_INT;
                else if (tag[20:0] == 21'd3) r = VC_TICK;
            end
        end
        return r;
    endfunction
endpackage
`default_nettype wire

[hw/rtl/bertlv_val.sv]
// Content value unit: integer accumulation and OID arc assembly for one byte.
`default_nettype none
module bertlv_val
    import bertlv_pkg::*;
(
    input  wire t_vclass    i_vc,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_last,
    input  wire t_val_st    i_st,
    output t_val_res        o_res
);
    logic [31:0] s;
    logic [31:0] sub;
    logic [1:0]  a;

    always_comb begin
        o_res    = '0;
        o_res.st = i_st;
        s   = '0;
        a   = '0;
        sub = '0;
        if (i_vc == VC_INT || i_vc == VC_TICK) begin
            if (i_st.gcnt < 3'd4) begin
                o_res.st.acc  = {i_st.acc[23:0], i_byte};
                o_res.st.gcnt = i_st.gcnt + 3'd1;
            end else if (i_st.gcnt != GCNT_DEAD) begin
                o_res.ovf     = 1'b1;
                o_res.st.gcnt = GCNT_DEAD;
            end
            if (i_last && o_res.st.gcnt != GCNT_DEAD) begin
                o_res.nvals = 2'd1;
                o_res.v0    = o_res.st.acc;
                o_res.kind  = (i_vc == VC_TICK) ? KIND_TICK : KIND_INT;
            end
        end else if (i_vc == VC_OID || i_vc == VC_ROID) begin
            if (i_st.gcnt != GCNT_DEAD) begin
                if (i_st.acc[31:25] != 7'd0) begin
                    o_res.ovf     = 1'b1;
                    o_res.st.gcnt = GCNT_DEAD;
                end else begin
                    o_res.st.acc = {i_st.acc[24:0], i_byte[6:0]};
                    if (i_st.gcnt < 3'd6) o_res.st.gcnt = i_st.gcnt + 3'd1;
                end
            end
            if (!i_byte[7]) begin
                if (o_res.st.gcnt != GCNT_DEAD) begin
                    s          = o_res.st.acc;
                    o_res.kind = KIND_OID;
                    if (i_st.fsp) begin
                        if (s < 32'd40) begin
                            a = 2'd0; sub = 32'd0;
                        end else if (s < 32'd80) begin
                            a = 2'd1; sub = 32'd40;
                        end else begin
                            a = 2'd2; sub = 32'd80;
                        end
                        o_res.nvals = 2'd2;
                        o_res.v0    = {30'd0, a};
                        o_res.v1    = s - sub;
                    end else begin
                        o_res.nvals = 2'd1;
                        o_res.v0    = s;
                    end
                end
                o_res.st = '0;
            end
        end
    end
endmodule
`default_nettype wire

[hw/rtl/ber_tlv_stream_parser_core.sv]
// Top level of the BER TLV stream parser: parse state, level stack and output stage.
`default_nettype none
// One message byte is taken per transfer and classified in the same cycle; each byte
// yields one result transfer, except the byte that ends the first OBJECT IDENTIFIER
// subidentifier, which yields two (first arc, then second arc), so the input stalls
// for the second arc. Otherwise one byte per clock is sustained: the output register
// accepts a new byte whenever its current result is taken. Nesting closes of several
// definite levels on one byte are resolved in that same cycle against the level stack.
module ber_tlv_stream_parser_core
    import bertlv_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [15:0] i_cfg_wr_data,   // max_message_length
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,  // [7:0] data_byte
    input  wire logic        i_s_axis_tuser,  // [0] first_of_message
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [2:0] byte_role, [6:3] nest_depth, [8:7] tag_class, [29:9] tag_number,
    // [30] is_constructed, [46:31] content_length, [47] value_ready,
    // [79:48] value, [82:80] error_code, [83] message_done, [87:84] zero
    output logic [87:0]      o_m_axis_tdata,
    output logic [1:0]       o_m_axis_tuser,  // [1:0] value_kind
    output logic             o_m_axis_tlast   // last_of_run
);
    typedef enum logic [2:0] {
        PH_TAG, PH_TAGC, PH_LEN, PH_LENX, PH_BODY, PH_EOC, PH_DONE, PH_HALT
    } t_phase;

    logic [15:0]      r_maxlen;
    logic [POS_W-1:0] r_pos, n_pos, s_pos;
    t_phase           r_phase, n_phase, s_phase;
    logic [23:0]      r_tag, n_tag, s_tag;
    logic [15:0]      r_lacc, n_lacc, s_lacc;
    logic [15:0]      r_crem, n_crem, s_crem;
    logic [POS_W:0]   r_stk [NEST_DEPTH];
    logic [SP_W-1:0]  r_sp, n_sp, s_sp;
    t_val_st          r_vst, n_vst, s_vst;

    logic             r_ovalid, r_pend, r_olast;
    logic [87:0]      r_odata;
    logic [1:0]       r_ouser;
    logic [31:0]      r_pval;

    logic             accept, first;
    logic [7:0]       b;
    logic [POS_W:0]   nxt, top, push_entry, sc_end;
    logic             top_def, push, sc, sc_indef, do_close, popping, cons;
    logic [15:0]      sc_len;
    logic [SP_W-1:0]  sp_base, cl_sp;
    logic [NEST_DEPTH-1:0] match;
    logic [2:0]       role, err, gnext;
    logic             show, done;
    t_vclass          vc;
    t_val_res         vres;
    logic [1:0]       nvals, kind;
    logic [31:0]      v0, v1;

    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = !r_ovalid || (i_m_axis_tready && !r_pend);
    assign first           = i_s_axis_tuser;
    assign b               = i_s_axis_tdata;

    assign s_pos   = first ? '0 : r_pos;
    assign s_phase = first ? PH_TAG : r_phase;
    assign s_tag   = first ? '0 : r_tag;
    assign s_lacc  = first ? '0 : r_lacc;
    assign s_crem  = first ? '0 : r_crem;
    assign s_sp    = first ? '0 : r_sp;
    assign s_vst   = first ? '0 : r_vst;

    assign nxt     = {1'b0, s_pos} + {{POS_W{1'b0}}, 1'b1};
    assign top     = r_stk[IDX_W'(s_sp - SP_W'(1))];
    assign top_def = (s_sp != '0) && !top[POS_W];
    assign vc      = value_class(s_tag);
    assign cons    = s_tag[21];
    assign sp_base = (s_phase == PH_EOC && s_sp != '0) ? s_sp - SP_W'(1) : s_sp;

    always_comb begin
        for (int i = 0; i < NEST_DEPTH; i++) begin
            match[i] = !r_stk[i][POS_W] && ({1'b0, r_stk[i][POS_W-1:0]} == nxt);
        end
    end

    always_comb begin
        popping = 1'b1;
        cl_sp   = sp_base;
        for (int i = NEST_DEPTH - 1; i >= 0; i--) begin
            if (i < int'(sp_base)) begin
                if (popping && match[i]) cl_sp = SP_W'(i);
                else popping = 1'b0;
            end
        end
    end

    bertlv_val u_val (
        .i_vc   (vc),
        .i_byte (b),
        .i_last (s_crem <= 16'd1),
        .i_st   (s_vst),
        .o_res  (vres)
    );

    always_comb begin
        n_pos      = (s_pos < POS_MAX) ? s_pos + POS_W'(1) : s_pos;
        n_phase    = s_phase;
        n_tag      = s_tag;
        n_lacc     = s_lacc;
        n_crem     = s_crem;
        n_sp       = s_sp;
        n_vst      = s_vst;
        role       = ROLE_PAD;
        show       = 1'b0;
        err        = ERR_NONE;
        done       = 1'b0;
        nvals      = 2'd0;
        v0         = '0;
        v1         = '0;
        kind       = KIND_INT;
        sc         = 1'b0;
        sc_indef   = 1'b0;
        sc_len     = '0;
        do_close   = 1'b0;
        push       = 1'b0;
        push_entry = '0;
        gnext      = '0;
        sc_end     = '0;
        if (s_phase == PH_DONE) begin
            done = 1'b1;
        end else if (s_phase == PH_HALT) begin
            done = 1'b0;
        end else if (s_pos >= r_maxlen || s_pos == POS_MAX) begin
            err = ERR_MLEN; n_phase = PH_HALT;
        end else if (top_def && s_pos >= top[POS_W-1:0]) begin
            err = ERR_LVL; n_phase = PH_HALT;
        end else begin
            case (s_phase)
                PH_TAG: begin
                    if (b == 8'h00) begin
                        role = ROLE_EOC;
                        if (s_sp != '0 && top[POS_W]) n_phase = PH_EOC;
                        else begin
                            err = ERR_EOC; n_phase = PH_HALT;
                        end
                    end else begin
                        role   = ROLE_TAG;
                        show   = 1'b1;
                        n_tag  = {b[7:6], b[5], 16'd0, (b[4:0] == 5'h1F) ? 5'd0 : b[4:0]};
                        n_lacc = '0;
                        n_vst.gcnt = '0;
                        n_phase = (b[4:0] == 5'h1F) ? PH_TAGC : PH_LEN;
                    end
                end
                PH_TAGC: begin
                    role = ROLE_TAGC;
                    show = 1'b1;
                    if (s_vst.gcnt >= 3'd3) begin
                        err = ERR_OVF; n_phase = PH_HALT;
                    end else begin
                        n_tag      = {s_tag[23:21], s_tag[13:0], b[6:0]};
                        n_vst.gcnt = s_vst.gcnt + 3'd1;
                        if (!b[7]) n_phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    role = ROLE_LEN;
                    show = 1'b1;
                    if (b == 8'h80) begin
                        sc = 1'b1; sc_indef = 1'b1;
                    end else if (b[7]) begin
                        if (b[6:0] == 7'd1 || b[6:0] == 7'd2) begin
                            n_vst.gcnt = b[2:0];
                            n_lacc     = '0;
                            n_phase    = PH_LENX;
                        end else begin
                            err = ERR_LFRM; n_phase = PH_HALT;
                        end
                    end else begin
                        sc = 1'b1; sc_len = {8'd0, b};
                    end
                end
                PH_LENX: begin
                    role       = ROLE_LENX;
                    show       = 1'b1;
                    n_lacc     = {s_lacc[7:0], b};
                    gnext      = (s_vst.gcnt != '0) ? s_vst.gcnt - 3'd1 : 3'd0;
                    n_vst.gcnt = gnext;
                    if (gnext == '0) begin
                        sc = 1'b1; sc_len = n_lacc;
                    end
                end
                PH_BODY: begin
                    role   = ROLE_CONT;
                    show   = 1'b1;
                    n_vst  = vres.st;
                    if (vres.ovf) err = ERR_OVF;
                    nvals  = vres.nvals;
                    v0     = vres.v0;
                    v1     = vres.v1;
                    kind   = vres.kind;
                    n_crem = s_crem - 16'd1;
                    if (n_crem == '0) do_close = 1'b1;
                end
                PH_EOC: begin
                    role = ROLE_EOC;
                    if (b != 8'h00) begin
                        err = ERR_EOC; n_phase = PH_HALT;
                    end else begin
                        do_close = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_HALT;
                end
            endcase
            if (sc) begin
                n_lacc = sc_indef ? 16'd0 : sc_len;
                sc_end = nxt + {1'b0, sc_len};
                if (sc_end > {1'b0, POS_MAX}) sc_end = {1'b0, POS_MAX};
                if (cons && (sc_indef || sc_len != '0)) begin
                    if (s_sp >= SP_W'(NEST_DEPTH)) begin
                        err = ERR_LVL; n_phase = PH_HALT;
                    end else if (!sc_indef && top_def &&
                                 sc_end[POS_W-1:0] > top[POS_W-1:0]) begin
                        err = ERR_LVL; n_phase = PH_HALT;
                    end else begin
                        push       = 1'b1;
                        push_entry = sc_indef ? {1'b1, {POS_W{1'b0}}} : sc_end;
                        n_sp       = s_sp + SP_W'(1);
                        n_phase    = PH_TAG;
                    end
                end else if (!cons && !sc_indef && sc_len != '0) begin
                    n_crem  = sc_len;
                    n_vst   = '0;
                    n_vst.fsp = (vc == VC_OID);
                    n_phase = PH_BODY;
                end else begin
                    do_close = 1'b1;
                end
            end
            if (do_close) begin
                n_sp = cl_sp;
                if (cl_sp == '0) begin
                    n_phase = PH_DONE; done = 1'b1;
                end else begin
                    n_phase = PH_TAG;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && push) r_stk[IDX_W'(s_sp)] <= push_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_maxlen <= MAX_LEN_RST;
            r_pos    <= '0;
            r_phase  <= PH_TAG;
            r_tag    <= '0;
            r_lacc   <= '0;
            r_crem   <= '0;
            r_sp     <= '0;
            r_vst    <= '0;
            r_ovalid <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_maxlen <= i_cfg_wr_data;
            if (accept) begin
                r_pos   <= n_pos;
                r_phase <= n_phase;
                r_tag   <= n_tag;
                r_lacc  <= n_lacc;
                r_crem  <= n_crem;
                r_sp    <= n_sp;
                r_vst   <= n_vst;
            end
            if (accept) begin
                r_ovalid <= 1'b1;
                r_pend   <= (nvals == 2'd2);
            end else if (r_ovalid && i_m_axis_tready) begin
                if (r_pend) r_pend <= 1'b0;
                else r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_odata <= {4'd0, done, err, v0, (nvals != 2'd0),
                        show ? n_lacc : 16'd0, show ? n_tag[21] : 1'b0,
                        show ? n_tag[20:0] : 21'd0, show ? n_tag[23:22] : 2'd0,
                        4'(s_sp), role};
            r_ouser <= kind;
            r_olast <= (nvals != 2'd2);
            r_pval  <= v1;
        end else if (r_ovalid && i_m_axis_tready && r_pend) begin
            r_odata[79:48] <= r_pval;
            r_olast        <= 1'b1;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ouser;
    assign o_m_axis_tlast  = r_olast;

    a_pend_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_ovalid && !r_olast) else $error("pending arc without first result");
    a_pend_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> !o_s_axis_tready) else $error("input taken while second arc pending");
    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SP_W'(NEST_DEPTH)) else $error("level stack pointer out of range");
    a_done_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DONE |-> r_sp == '0) else $error("done with levels open");
endmodule
`default_nettype wire
